// ===== design/bpbb_pkg.sv =====
// Shared types and constants for the Bezier path bounding box block.
// Used by the divider, the multiplier wrapper and the top level.
package bpbb_pkg;

	typedef logic [2:0] opcode_t;

	localparam opcode_t OP_CLEAR = 3'd0;
	localparam opcode_t OP_MOVE  = 3'd1;
	localparam opcode_t OP_LINE  = 3'd2;
	localparam opcode_t OP_QUAD  = 3'd3;
	localparam opcode_t OP_CUBIC = 3'd4;
	localparam opcode_t OP_CLOSE = 3'd5;

	// |a-2b+c| of 32-bit coordinates stays below 2^33
	localparam int DIV_W = 34;
	localparam int MUL_W = 33;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_req_t;

endpackage

// ===== design/bpbb_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on bpbb_pkg for the operand width.
module bpbb_mul import bpbb_pkg::*; (
	input  logic                      clk,
	input  logic signed [MUL_W-1:0]   a,
	input  logic signed [MUL_W-1:0]   b,
	output logic signed [2*MUL_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

// ===== design/bpbb_div.sv =====
// Restoring divider, one quotient bit per cycle: floor(num * 2^F / den), num <= den.
// Depends on bpbb_pkg for the request struct.
module bpbb_div import bpbb_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  div_req_t           req,
	output logic               done_q,
	output logic [FRAC_BITS:0] quot_q
);

	localparam int CW = $clog2(FRAC_BITS + 2);

	logic [DIV_W:0]   rem_q;
	logic [DIV_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             ge;

	assign ge = rem_q >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q  <= {1'b0, req.num};
				den_q  <= req.den;
				quot_q <= '0;
				cnt_q  <= CW'(FRAC_BITS + 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (ge) begin
					rem_q <= (rem_q - {1'b0, den_q}) << 1;
				end else begin
					rem_q <= rem_q << 1;
				end
				quot_q <= {quot_q[FRAC_BITS-1:0], ge};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== design/bezier_path_bounding_box.sv =====
// Bezier path bounding box: sequencer, box state and output register.
// Depends on bpbb_pkg, bpbb_mul and bpbb_div.
//
// Usage: path elements arrive on s_tvalid/s_tready, opcode in s_tuser, points in
// s_tdata. Each request yields one result on m_tvalid/m_tready: the running box
// scaled by the scale register (cfg_wen/cfg_wdata), plus an empty flag in m_tuser.
// All multiplications run through one shared 33x33 multiplier (linear
// interpolations and scaled bounds) and divisions through a bit-serial divider.
// Every request ends by scaling the four bounds one after another.
// Quadratic: before that, up to two extrema, one per axis, each found by a divide.
// Cubic: before that, CUBIC_STEPS+1 samples, each with six interpolations per
// axis on the shared multiplier.
// s_tready is high only while the sequencer is idle, one request at a time.
// A finished result sits in the output register; the next request is taken
// while it waits, and the sequencer holds its next result until the slot frees.
// Reset clears the box and current point, marks the box empty and sets scale 1.0.
module bezier_path_bounding_box import bpbb_pkg::*; #(
	parameter int CUBIC_STEPS = 100,
	parameter int FRAC_BITS   = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,  // end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y
	input  logic [2:0]   s_tuser,  // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,  // min_x_scaled, min_y_scaled, max_x_scaled, max_y_scaled
	output logic         m_tuser,  // box_empty
	input  logic         cfg_wen,
	input  logic [31:0]  cfg_wdata
);

	localparam int TW = FRAC_BITS + 1;
	localparam int IW = $clog2(CUBIC_STEPS + 1);
	localparam int RW = $clog2(CUBIC_STEPS);
	localparam int T_Q = (1 << FRAC_BITS) / CUBIC_STEPS;
	localparam int T_R = (1 << FRAC_BITS) % CUBIC_STEPS;
	localparam int PW = 2 * MUL_W;

	typedef enum logic [3:0] {
		S_IDLE, S_ADD_END, S_QCHK, S_QDIV, S_LOAD, S_MUL, S_ACC,
		S_SCALE_MUL, S_SCALE_ACC, S_OUT
	} state_t;

	state_t state_q;
	opcode_t op_q;
	logic signed [31:0] px_q [4];
	logic signed [31:0] py_q [4];
	logic signed [31:0] w_q [4];
	logic signed [31:0] cur_x_q, cur_y_q, sx_q;
	logic signed [31:0] bmin_x_q, bmax_x_q, bmin_y_q, bmax_y_q;
	logic signed [31:0] res_q [4];
	logic        empty_q, axis_q;
	logic [1:0]  j_q, lim_q, sidx_q;
	logic [TW-1:0] t_q;
	logic [IW-1:0] i_q;
	logic [RW-1:0] tr_q;
	logic [31:0] scale_q;

	logic accept;
	logic signed [31:0] e_x, e_y, c1_x, c1_y, c2_x, c2_y;
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod_q, sh;
	logic signed [31:0] lerp_r, bound, sat_r;
	logic eval_done;
	logic pt_en, ax_en;
	logic signed [31:0] pt_x, pt_y;
	logic signed [31:0] qa, qb, qc;
	logic signed [32:0] qn;
	logic signed [34:0] qd;
	logic [DIV_W-1:0] an, ad;
	logic q_ok;
	logic [RW:0] tr_sum;
	div_req_t div_req;
	logic div_done;
	logic [TW-1:0] div_quot;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign {c2_y, c2_x, c1_y, c1_x, e_y, e_x} = s_tdata;

	bpbb_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_q(prod_q));

	bpbb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .done_q(div_done), .quot_q(div_quot)
	);

	// shared multiplier operands: interpolation delta * t, or bound * scale
	always_comb begin
		case (sidx_q)
			2'd0:    bound = bmin_x_q;
			2'd1:    bound = bmin_y_q;
			2'd2:    bound = bmax_x_q;
			default: bound = bmax_y_q;
		endcase
		if (state_q == S_SCALE_MUL) begin
			mul_a = MUL_W'(bound);
			mul_b = $signed({1'b0, scale_q});
		end else begin
			mul_a = MUL_W'(w_q[j_q + 2'd1]) - MUL_W'(w_q[j_q]);
			mul_b = $signed(MUL_W'(t_q));
		end
	end

	assign lerp_r = w_q[j_q] + prod_q[FRAC_BITS +: 32];
	assign eval_done = (j_q == lim_q) && (lim_q == 2'd0);

	always_comb begin
		sh = prod_q >>> FRAC_BITS;
		if (sh > $signed(PW'(64'sd2147483647))) begin
			sat_r = 32'sh7fffffff;
		end else if (sh < $signed(-PW'(64'sd2147483648))) begin
			sat_r = 32'sh80000000;
		end else begin
			sat_r = sh[31:0];
		end
	end

	// quadratic extremum check on the current axis
	always_comb begin
		qa = axis_q ? py_q[0] : px_q[0];
		qb = axis_q ? py_q[1] : px_q[1];
		qc = axis_q ? py_q[2] : px_q[2];
		qn = 33'(qa) - 33'(qb);
		qd = 35'(qa) - (35'(qb) <<< 1) + 35'(qc);
		an = DIV_W'(qn[32] ? 33'(-qn) : 33'(qn));
		ad = DIV_W'(qd[34] ? -qd : qd);
		q_ok = (qd != '0) && !(qn > 0 && qd < 0) && !(qn < 0 && qd > 0) && (an <= ad);
		div_req.start = (state_q == S_QCHK) && q_ok;
		div_req.num = an;
		div_req.den = ad;
	end

	assign tr_sum = (RW + 1)'(tr_q) + (RW + 1)'(T_R);

	always_comb begin
		pt_en = 1'b0;
		ax_en = 1'b0;
		pt_x = cur_x_q;
		pt_y = cur_y_q;
		case (state_q)
			S_IDLE: begin
				if (accept && (s_tuser == OP_MOVE || s_tuser == OP_LINE)) begin
					pt_en = 1'b1;
					pt_x = e_x;
					pt_y = e_y;
				end else if (accept && (s_tuser == OP_QUAD || s_tuser == OP_CUBIC)) begin
					pt_en = 1'b1;
				end
			end
			S_ADD_END: begin
				pt_en = 1'b1;
				pt_x = px_q[2];
				pt_y = py_q[2];
			end
			S_ACC: begin
				if (eval_done && op_q == OP_CUBIC && axis_q) begin
					pt_en = 1'b1;
					pt_x = sx_q;
					pt_y = lerp_r;
				end else if (eval_done && op_q == OP_QUAD) begin
					ax_en = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			m_tvalid <= 1'b0;
			empty_q  <= 1'b1;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			bmin_x_q <= '0;
			bmax_x_q <= '0;
			bmin_y_q <= '0;
			bmax_y_q <= '0;
			scale_q  <= 32'(1) << FRAC_BITS;
			axis_q   <= 1'b0;
			j_q      <= '0;
			lim_q    <= '0;
			sidx_q   <= '0;
		end else begin
			if (cfg_wen) begin
				scale_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q <= s_tuser;
						px_q[0] <= cur_x_q;
						py_q[0] <= cur_y_q;
						px_q[1] <= c1_x;
						py_q[1] <= c1_y;
						px_q[2] <= (s_tuser == OP_QUAD) ? e_x : c2_x;
						py_q[2] <= (s_tuser == OP_QUAD) ? e_y : c2_y;
						px_q[3] <= e_x;
						py_q[3] <= e_y;
						axis_q <= 1'b0;
						sidx_q <= '0;
						i_q <= '0;
						t_q <= '0;
						tr_q <= RW'(CUBIC_STEPS / 2);
						case (s_tuser)
							OP_CLEAR: begin
								empty_q  <= 1'b1;
								cur_x_q  <= '0;
								cur_y_q  <= '0;
								bmin_x_q <= '0;
								bmax_x_q <= '0;
								bmin_y_q <= '0;
								bmax_y_q <= '0;
								state_q  <= S_SCALE_MUL;
							end
							OP_MOVE, OP_LINE: begin
								cur_x_q <= e_x;
								cur_y_q <= e_y;
								state_q <= S_SCALE_MUL;
							end
							OP_QUAD:  state_q <= S_ADD_END;
							OP_CUBIC: state_q <= S_LOAD;
							default:  state_q <= S_SCALE_MUL;
						endcase
					end
				end
				S_ADD_END: state_q <= S_QCHK;
				S_QCHK: begin
					if (q_ok) begin
						state_q <= S_QDIV;
					end else if (!axis_q) begin
						axis_q <= 1'b1;
					end else begin
						cur_x_q <= px_q[3];
						cur_y_q <= py_q[3];
						state_q <= S_SCALE_MUL;
					end
				end
				S_QDIV: begin
					if (div_done) begin
						t_q <= div_quot;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					for (int k = 0; k < 4; k++) begin
						w_q[k] <= axis_q ? py_q[k] : px_q[k];
					end
					j_q <= '0;
					lim_q <= (op_q == OP_CUBIC) ? 2'd2 : 2'd1;
					state_q <= S_MUL;
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					w_q[j_q] <= lerp_r;
					if (j_q != lim_q) begin
						j_q <= j_q + 2'd1;
						state_q <= S_MUL;
					end else if (lim_q != 2'd0) begin
						j_q <= '0;
						lim_q <= lim_q - 2'd1;
						state_q <= S_MUL;
					end else if (op_q == OP_CUBIC) begin
						if (!axis_q) begin
							sx_q <= lerp_r;
							axis_q <= 1'b1;
							state_q <= S_LOAD;
						end else if (i_q == IW'(CUBIC_STEPS)) begin
							cur_x_q <= px_q[3];
							cur_y_q <= py_q[3];
							state_q <= S_SCALE_MUL;
						end else begin
							// next t = round(i/N), stepped by 2^F/N with a remainder
							axis_q <= 1'b0;
							i_q <= i_q + 1'b1;
							state_q <= S_LOAD;
							if (tr_sum >= (RW + 1)'(CUBIC_STEPS)) begin
								tr_q <= RW'(tr_sum - (RW + 1)'(CUBIC_STEPS));
								t_q <= t_q + TW'(T_Q + 1);
							end else begin
								tr_q <= RW'(tr_sum);
								t_q <= t_q + TW'(T_Q);
							end
						end
					end else if (!axis_q) begin
						axis_q <= 1'b1;
						state_q <= S_QCHK;
					end else begin
						cur_x_q <= px_q[3];
						cur_y_q <= py_q[3];
						state_q <= S_SCALE_MUL;
					end
				end
				S_SCALE_MUL: state_q <= S_SCALE_ACC;
				S_SCALE_ACC: begin
					res_q[sidx_q] <= sat_r;
					sidx_q <= sidx_q + 2'd1;
					state_q <= (sidx_q == 2'd3) ? S_OUT : S_SCALE_MUL;
				end
				S_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tdata  <= {res_q[3], res_q[2], res_q[1], res_q[0]};
						m_tuser  <= empty_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (state_q == S_OUT && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end

			if (pt_en) begin
				if (empty_q) begin
					bmin_x_q <= pt_x;
					bmax_x_q <= pt_x;
					bmin_y_q <= pt_y;
					bmax_y_q <= pt_y;
					empty_q  <= 1'b0;
				end else begin
					if (pt_x < bmin_x_q) bmin_x_q <= pt_x;
					if (pt_x > bmax_x_q) bmax_x_q <= pt_x;
					if (pt_y < bmin_y_q) bmin_y_q <= pt_y;
					if (pt_y > bmax_y_q) bmax_y_q <= pt_y;
				end
			end
			if (ax_en) begin
				if (!axis_q) begin
					if (lerp_r < bmin_x_q) bmin_x_q <= lerp_r;
					if (lerp_r > bmax_x_q) bmax_x_q <= lerp_r;
				end else begin
					if (lerp_r < bmin_y_q) bmin_y_q <= lerp_r;
					if (lerp_r > bmax_y_q) bmax_y_q <= lerp_r;
				end
			end
		end
	end

endmodule

// ===== design/bpbb_checker.sv =====
// Port-level checks for the Bezier path bounding box, bound to the top level.
// Depends on bezier_path_bounding_box port names only.
module bpbb_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [191:0] s_tdata,
	input logic [2:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic         m_tuser,
	input logic         cfg_wen,
	input logic [31:0]  cfg_wdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// empty box reports zero bounds
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("empty box with nonzero bounds");

	// scaled box stays ordered
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[31:0]) <= $signed(m_tdata[95:64]))
			&& ($signed(m_tdata[63:32]) <= $signed(m_tdata[127:96])))
		else $error("min above max");

endmodule

bind bezier_path_bounding_box bpbb_checker u_bpbb_checker (.*);
